// File: rtl/bmp_rle_decoder_macros.svh
// Assertion macros shared by the BMP RLE decoder RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef BMP_RLE_DECODER_MACROS_SVH
`define BMP_RLE_DECODER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmp_rle_decoder assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define BRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmp_rle_decoder assertion failed");

`endif

// File: rtl/brd_pkg.sv
// Types, codes and constants of the BMP RLE decoder.
// Used by brd_core and bmp_rle_decoder; depends on nothing.
`default_nettype none

package brd_pkg;

  localparam int unsigned BRD_ADDRESS_BITS = 24;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RLE_MODE   = 2'd0;
  localparam logic [1:0] CFG_ROW_STRIDE = 2'd1;
  localparam logic [1:0] CFG_DEST_SIZE  = 2'd2;

  // Escape codes that follow a zero count byte.
  localparam logic [7:0] ESC_EOL   = 8'h00;
  localparam logic [7:0] ESC_EOB   = 8'h01;
  localparam logic [7:0] ESC_DELTA = 8'h02;

  localparam logic [15:0] COL_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_BOUNDS = 2'd1,
    ERR_ODD    = 2'd2,
    ERR_TRUNC  = 2'd3
  } brd_err_e;

  typedef enum logic [6:0] {
    PH_COUNT   = 7'b0000001,
    PH_VALUE   = 7'b0000010,
    PH_ESCAPE  = 7'b0000100,
    PH_DELTA_X = 7'b0001000,
    PH_DELTA_Y = 7'b0010000,
    PH_LITERAL = 7'b0100000,
    PH_PAD     = 7'b1000000
  } brd_phase_e;

  typedef struct packed {
    logic [7:0] coded_byte;
    logic       last_byte;
  } brd_in_t;

  typedef struct packed {
    logic [23:0] write_address;
    logic [7:0]  fill_value;
    logic [7:0]  fill_count;
    logic        image_end;
    logic [1:0]  error_code;
  } brd_out_t;

  typedef struct packed {
    logic        rle_mode;
    logic [15:0] row_stride;
    logic [23:0] dest_size;
  } brd_cfg_t;

endpackage

`default_nettype wire

// File: rtl/brd_core.sv
// Parser state and combinational step logic of the BMP RLE decoder.
// Depends on brd_pkg; instantiated by bmp_rle_decoder.
`default_nettype none

module brd_core import brd_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = BRD_ADDRESS_BITS
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     fire_i,
  input  wire brd_in_t  item_i,
  input  wire brd_cfg_t cfg_i,
  output logic          res_valid_o,
  output brd_out_t      res_o
);

  localparam logic [32:0] AddrLimit = 33'(1) << ADDRESS_BITS;

  brd_phase_e  phase_q, phase_d;
  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic [23:0] ptr_q, ptr_d;
  logic [7:0]  plen_q, plen_d;
  logic [7:0]  lleft_q, lleft_d;
  logic        parity_q, parity_d;
  logic [7:0]  dx_q, dx_d;
  logic        fin_q, fin_d;

  logic        four;
  logic [7:0]  b;
  logic        last;
  logic [23:0] de;
  logic [7:0]  run_c, lit_c, chk_c;
  logic        fits;
  logic [7:0]  col_arg;
  logic [16:0] col_raw;
  logic [15:0] col_sum;
  logic [16:0] mul_row;
  logic [31:0] prod;
  logic [15:0] xoff;
  logic [32:0] pos;
  logic        pos_ok;
  logic [7:0]  lleft_next;

  logic        n;
  logic        is_end;
  brd_err_e    err;
  logic [23:0] addr;
  logic [7:0]  val;
  logic [7:0]  cnt;

  assign four = cfg_i.rle_mode;
  assign b    = item_i.coded_byte;
  assign last = item_i.last_byte;

  // The usable limit is the smaller of dest_size and the address space; it fits 24 bits.
  assign de = ({9'b0, cfg_i.dest_size} < AddrLimit) ? cfg_i.dest_size : AddrLimit[23:0];

  assign run_c = four ? {1'b0, plen_q[7:1]} : plen_q;
  assign lit_c = four ? {1'b0, b[7:1]} : b;
  assign chk_c = (phase_q == PH_VALUE) ? run_c : lit_c;
  // The pointer never passes the limit, so the space check is an add and a compare.
  assign fits  = ({1'b0, ptr_q} + {17'b0, chk_c}) <= {1'b0, de};

  always_comb begin
    case (phase_q)
      PH_VALUE:  col_arg = plen_q;
      PH_ESCAPE: col_arg = b;
      default:   col_arg = dx_q;
    endcase
  end
  assign col_raw = {1'b0, col_q} + {9'b0, col_arg};
  assign col_sum = col_raw[16] ? COL_MAX : col_raw[15:0];

  // End of line and delta share one row multiplier.
  assign mul_row = (phase_q == PH_ESCAPE) ? ({1'b0, row_q} + 17'd1)
                                          : ({1'b0, row_q} + {9'b0, b});
  assign prod    = {16'b0, mul_row[15:0]} * {16'b0, cfg_i.row_stride};
  assign xoff    = (phase_q == PH_DELTA_Y) ? (four ? {1'b0, col_sum[15:1]} : col_sum)
                                           : 16'd0;
  assign pos     = {1'b0, prod} + {17'b0, xoff};
  assign pos_ok  = !mul_row[16] && (pos < {9'b0, de});

  assign lleft_next = (lleft_q == 8'd0) ? 8'd0 : lleft_q - 8'd1;

  always_comb begin
    phase_d  = phase_q;
    col_d    = col_q;
    row_d    = row_q;
    ptr_d    = ptr_q;
    plen_d   = plen_q;
    lleft_d  = lleft_q;
    dx_d     = dx_q;
    fin_d    = fin_q;
    parity_d = ~parity_q;
    n        = 1'b0;
    is_end   = 1'b0;
    err      = ERR_NONE;
    addr     = 24'd0;
    val      = 8'd0;
    cnt      = 8'd0;

    case (phase_q)
      PH_COUNT: begin
        if (b == 8'd0) begin
          phase_d = PH_ESCAPE;
        end else if (four && b[0]) begin
          err = ERR_ODD;
        end else begin
          plen_d  = b;
          phase_d = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (!fits) begin
          err = ERR_BOUNDS;
        end else begin
          n       = 1'b1;
          addr    = ptr_q;
          val     = b;
          cnt     = run_c;
          ptr_d   = ptr_q + {16'b0, run_c};
          col_d   = col_sum;
          phase_d = PH_COUNT;
        end
      end
      PH_ESCAPE: begin
        if (b == ESC_EOL) begin
          if (!pos_ok) begin
            err = ERR_BOUNDS;
          end else begin
            row_d   = mul_row[15:0];
            col_d   = 16'd0;
            ptr_d   = pos[23:0];
            phase_d = PH_COUNT;
          end
        end else if (b == ESC_EOB) begin
          n      = 1'b1;
          is_end = 1'b1;
        end else if (b == ESC_DELTA) begin
          phase_d = PH_DELTA_X;
        end else if (four && b[0]) begin
          err = ERR_ODD;
        end else if (!fits) begin
          err = ERR_BOUNDS;
        end else begin
          lleft_d = lit_c;
          col_d   = col_sum;
          phase_d = PH_LITERAL;
        end
      end
      PH_DELTA_X: begin
        dx_d    = b;
        phase_d = PH_DELTA_Y;
      end
      PH_DELTA_Y: begin
        if (!pos_ok) begin
          err = ERR_BOUNDS;
        end else begin
          col_d   = col_sum;
          row_d   = mul_row[15:0];
          ptr_d   = pos[23:0];
          phase_d = PH_COUNT;
        end
      end
      PH_LITERAL: begin
        n       = 1'b1;
        addr    = ptr_q;
        val     = b;
        cnt     = 8'd1;
        ptr_d   = ptr_q + 24'd1;
        lleft_d = lleft_next;
        // A run that ends on an even source offset is followed by a pad byte.
        if (lleft_next == 8'd0) begin
          phase_d = parity_q ? PH_COUNT : PH_PAD;
        end
      end
      default: begin
        phase_d = PH_COUNT;
      end
    endcase

    if (err != ERR_NONE) begin
      n      = 1'b1;
      is_end = 1'b1;
      addr   = 24'd0;
      val    = 8'd0;
      cnt    = 8'd0;
    end else if (last && !is_end) begin
      n      = 1'b1;
      is_end = 1'b1;
      if (phase_d != PH_COUNT && phase_d != PH_PAD) begin
        err  = ERR_TRUNC;
        addr = 24'd0;
        val  = 8'd0;
        cnt  = 8'd0;
      end
    end

    if (is_end && !last) begin
      fin_d = 1'b1;
    end

    // After the image closes, bytes are dropped until the last one.
    if (fin_q) begin
      n        = 1'b0;
      phase_d  = phase_q;
      col_d    = col_q;
      row_d    = row_q;
      ptr_d    = ptr_q;
      plen_d   = plen_q;
      lleft_d  = lleft_q;
      dx_d     = dx_q;
      parity_d = parity_q;
      fin_d    = fin_q;
    end

    if ((is_end || fin_q) && last) begin
      phase_d  = PH_COUNT;
      col_d    = 16'd0;
      row_d    = 16'd0;
      ptr_d    = 24'd0;
      plen_d   = 8'd0;
      lleft_d  = 8'd0;
      dx_d     = 8'd0;
      parity_d = 1'b0;
      fin_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_COUNT;
      col_q    <= 16'd0;
      row_q    <= 16'd0;
      ptr_q    <= 24'd0;
      plen_q   <= 8'd0;
      lleft_q  <= 8'd0;
      parity_q <= 1'b0;
      dx_q     <= 8'd0;
      fin_q    <= 1'b0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      col_q    <= col_d;
      row_q    <= row_d;
      ptr_q    <= ptr_d;
      plen_q   <= plen_d;
      lleft_q  <= lleft_d;
      parity_q <= parity_d;
      dx_q     <= dx_d;
      fin_q    <= fin_d;
    end
  end

  assign res_valid_o         = fire_i && n;
  assign res_o.write_address = addr;
  assign res_o.fill_value    = val;
  assign res_o.fill_count    = cnt;
  assign res_o.image_end     = is_end;
  assign res_o.error_code    = err;

endmodule

`default_nettype wire

// File: rtl/bmp_rle_decoder.sv
// Top level of the BMP RLE8/RLE4 decoder: channels, configuration registers, pipeline.
// Depends on brd_pkg, brd_core and bmp_rle_decoder_macros.svh.
//
// Usage:
//   Compressed bytes enter on the in channel (coded_byte plus a last_byte flag);
//   fill commands leave on the out channel. Each command asks the receiver to
//   write fill_count copies of fill_value from write_address on; a command with
//   fill_count zero only reports the end of the image and its error code.
//   Registers are written on the cfg channel (index 0 mode, 1 row stride,
//   2 destination size); the user must write them only while no request is in
//   flight; the block does not enforce it. cfg_ready_o is always high. A byte
//   is held in the input register and its command, if any, in the output register.
//   Throughput: one byte per cycle while the receiver does not stall, set by the
//   single parse stage between the input register and the output register.
//   When the receiver stalls, the output register holds its command, the input
//   register holds one more byte, and in_ready_o drops only when both are full.
//   Reset empties both registers, returns the parser to the start of an image,
//   and sets mode RLE8, stride 4 and destination size 0. No clearing pass.
`default_nettype none
`include "bmp_rle_decoder_macros.svh"

module bmp_rle_decoder import brd_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = BRD_ADDRESS_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire brd_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output brd_out_t         out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);

  brd_cfg_t cfg_q;
  logic     s0_valid_q;
  brd_in_t  s0_data_q;
  logic     out_valid_q;
  brd_out_t out_data_q;
  logic     adv;
  logic     in_fire;
  logic     res_valid;
  brd_out_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rle_mode   <= 1'b0;
      cfg_q.row_stride <= 16'd4;
      cfg_q.dest_size  <= 24'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RLE_MODE:   cfg_q.rle_mode   <= cfg_data_i[0];
        CFG_ROW_STRIDE: cfg_q.row_stride <= cfg_data_i[15:0];
        CFG_DEST_SIZE:  cfg_q.dest_size  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The parse stage advances whenever the output register is free or being emptied.
  assign adv        = s0_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s0_valid_q || adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_fire) begin
      s0_valid_q <= 1'b1;
    end else if (adv) begin
      s0_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_data_q <= in_data_i;
    end
  end

  brd_core #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (adv),
    .item_i     (s0_data_q),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `BRD_ASSERT_NEXT(a_s0_holds_on_stall, clk_i, rst_ni,
                   s0_valid_q && out_valid_q && !out_ready_i,
                   s0_valid_q && $stable(s0_data_q))
  `BRD_ASSERT_NEXT(a_result_reaches_output, clk_i, rst_ni, res_valid, out_valid_o)
  `BRD_ASSERT_NEXT(a_error_closes_image, clk_i, rst_ni,
                   res_valid && (res.error_code != ERR_NONE), out_data_o.image_end)
  `BRD_ASSERT_NOW(a_no_fill_after_end, clk_i, rst_ni,
                  res_valid && res.image_end && (res.error_code != ERR_NONE),
                  res.fill_count == 8'd0)

endmodule

`default_nettype wire
